// File: rtl/core/lsh_pkg.sv
`default_nettype none

package lsh_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int DATA_W     = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int HEIGHT_W   = 12;
    localparam int CH_W       = 3;
    // Row counter runs one past the frame height during the drain tail.
    localparam int ROW_W      = 13;
    localparam int ACC_W      = 12;

    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int RST_CHANNELS     = 1;
    localparam int MIN_DIM          = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    // Control bits of an item between the address stage and the compute stage.
    typedef struct packed {
        logic valid;
        logic data;
        logic produced;
        logic calc;
        logic bwr;
        logic last;
    } t_s1;

    typedef struct packed {
        logic              last;
        logic [DATA_W-1:0] value;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/core/lsh_line_mem.sv
`default_nettype none

module lsh_line_mem
    import lsh_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // A read and a write to the same address in one cycle return the old word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/lsh_front.sv
`default_nettype none

module lsh_front
    import lsh_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int AW           = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [DATA_W-1:0]    i_sample,
    input  wire logic                 i_pad,
    output logic                      o_a_en,
    output logic      [AW-1:0]        o_a_addr,
    output logic      [DATA_W-1:0]    o_a_wdata,
    output logic                      o_b_re,
    output logic      [AW-1:0]        o_b_raddr,
    output t_s1                       o_s1,
    output logic      [AW-1:0]        o_s1_addr,
    output logic      [DATA_W-1:0]    o_s1_down,
    output logic      [CH_W-1:0]      o_chan
);

    localparam int XW     = AW + 1;
    localparam int DLY_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int W_RST  = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;

    logic [XW-1:0]       r_w;
    logic [HEIGHT_W-1:0] r_h;
    logic [CH_W-1:0]     r_c;
    logic [XW-1:0]       r_len;
    logic [AW-1:0]       r_x;
    logic [ROW_W-1:0]    r_r;
    logic [DATA_W-1:0]   r_dly [MAX_CHANNELS];
    t_s1                 r_s1;
    logic [AW-1:0]       r_li;
    logic [DATA_W-1:0]   r_down;

    logic [AW-1:0]       n_x;
    logic [ROW_W-1:0]    n_r;
    t_s1                 n_s1;

    logic                cfg_hit;
    logic [XW-1:0]       w_new;
    logic [HEIGHT_W-1:0] h_new;
    logic [CH_W-1:0]     c_new;
    logic [XW-1:0]       x_e;
    logic [XW-1:0]       x_inc;
    logic [XW-1:0]       c_e;
    logic [XW-1:0]       c2_e;
    logic [ROW_W-1:0]    h_e;
    logic                drain;
    logic                ge_c;
    logic                ge_2c;
    logic                r_ge2;
    logic                r_eq1;
    logic                is_data;
    logic                is_drain;
    logic                last;
    logic [AW-1:0]       li;

    always_comb begin
        cfg_hit = i_cfg_we && (i_cfg_index == REG_FRAME_WIDTH ||
                               i_cfg_index == REG_FRAME_HEIGHT ||
                               i_cfg_index == REG_CHANNEL_COUNT);

        if (i_cfg_data < CFG_W'(MIN_DIM)) begin
            w_new = XW'(MIN_DIM);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            w_new = XW'(MAX_WIDTH);
        end else begin
            w_new = XW'(i_cfg_data);
        end

        h_new = (i_cfg_data < CFG_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : i_cfg_data;

        if (i_cfg_data[CH_W-1:0] == '0) begin
            c_new = CH_W'(1);
        end else if (32'(i_cfg_data[CH_W-1:0]) > 32'(MAX_CHANNELS)) begin
            c_new = CH_W'(MAX_CHANNELS);
        end else begin
            c_new = i_cfg_data[CH_W-1:0];
        end
    end

    always_comb begin
        x_e      = {1'b0, r_x};
        x_inc    = x_e + XW'(1);
        c_e      = XW'(r_c);
        c2_e     = XW'({r_c, 1'b0});
        h_e      = {1'b0, r_h};
        drain    = (r_r >= h_e);
        ge_c     = (x_e >= c_e);
        ge_2c    = (x_e >= c2_e);
        r_ge2    = (r_r >= ROW_W'(2));
        r_eq1    = (r_r == ROW_W'(1));
        is_data  = i_accept && !drain && !i_pad;
        is_drain = i_accept && drain;
        // The frame ends on the last channel of the first pixel past the drain row.
        last     = is_drain && (r_r > h_e) && (x_inc >= c_e);
        li       = AW'(x_e - c_e);

        n_x = r_x;
        n_r = r_r;
        if (cfg_hit || last) begin
            n_x = '0;
            n_r = '0;
        end else if (is_data || is_drain) begin
            if (x_inc >= r_len) begin
                n_x = '0;
                n_r = r_r + ROW_W'(1);
            end else begin
                n_x = AW'(x_inc);
            end
        end

        n_s1.valid    = is_data || is_drain;
        n_s1.data     = is_data;
        n_s1.produced = is_drain || (is_data && (r_ge2 || (r_eq1 && ge_c)));
        n_s1.calc     = is_data && ge_2c && r_ge2;
        n_s1.bwr      = is_data && ge_c;
        n_s1.last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= XW'(W_RST);
            r_h   <= HEIGHT_W'(RST_FRAME_HEIGHT);
            r_c   <= CH_W'(RST_CHANNELS);
            r_len <= XW'(W_RST * RST_CHANNELS);
            r_x   <= '0;
            r_r   <= '0;
            r_s1  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        r_w   <= w_new;
                        r_len <= XW'(32'(w_new) * 32'(r_c));
                    end
                    REG_FRAME_HEIGHT: begin
                        r_h <= h_new;
                    end
                    REG_CHANNEL_COUNT: begin
                        r_c   <= c_new;
                        r_len <= XW'(32'(r_w) * 32'(c_new));
                    end
                    default: begin
                    end
                endcase
            end
            r_x  <= n_x;
            r_r  <= n_r;
            r_s1 <= n_s1;
        end
    end

    // Short delay of the current row gives the sample one pixel to the left.
    always_ff @(posedge i_clk) begin
        if (is_data) begin
            r_dly[0] <= i_sample;
            for (int i = 1; i < MAX_CHANNELS; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
            r_li   <= li;
            r_down <= r_dly[DLY_AW'(r_c - CH_W'(1))];
        end
    end

    assign o_a_en    = is_data;
    assign o_a_addr  = r_x;
    assign o_a_wdata = i_sample;
    assign o_b_re    = is_data && ge_c;
    assign o_b_raddr = li;
    assign o_s1      = r_s1;
    assign o_s1_addr = r_li;
    assign o_s1_down = r_down;
    assign o_chan    = r_c;

endmodule

`default_nettype wire

// File: rtl/core/lsh_calc.sv
`default_nettype none

module lsh_calc
    import lsh_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int AW           = $clog2(DEF_MAX_WIDTH * DEF_MAX_CHANNELS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_s1               i_s1,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [DATA_W-1:0] i_down,
    input  wire logic [CH_W-1:0]   i_chan,
    input  wire logic [DATA_W-1:0] i_prev,
    input  wire logic [DATA_W-1:0] i_up,
    output logic                   o_b_we,
    output logic      [AW-1:0]     o_b_waddr,
    output logic      [DATA_W-1:0] o_b_wdata,
    output logic                   o_push,
    output t_res                   o_res
);

    localparam int WIN    = 2 * MAX_CHANNELS;
    localparam int WIN_AW = (WIN > 1) ? $clog2(WIN) : 1;

    logic [DATA_W-1:0] r_win [WIN];

    logic [WIN_AW-1:0] idx_mid;
    logic [WIN_AW-1:0] idx_left;
    logic [DATA_W-1:0] mid;
    logic [DATA_W-1:0] left;
    logic [ACC_W-1:0]  acc;
    logic [DATA_W-1:0] clamped;

    // The window holds the previous row; before this item's shift the centre sits
    // one pixel back and the left neighbour two pixels back.
    always_comb begin
        idx_mid  = WIN_AW'(4'(i_chan) - 4'd1);
        idx_left = WIN_AW'({i_chan, 1'b0} - 4'd1);
        mid      = r_win[idx_mid];
        left     = r_win[idx_left];
        acc      = ACC_W'({mid, 2'b00}) + ACC_W'(mid) - ACC_W'(i_up) - ACC_W'(i_down)
                 - ACC_W'(left) - ACC_W'(i_prev);
        if (acc[ACC_W-1]) begin
            clamped = '0;
        end else if (acc > ACC_W'(255)) begin
            clamped = '1;
        end else begin
            clamped = acc[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_s1.valid && i_s1.data) begin
            r_win[0] <= i_prev;
            for (int i = 1; i < WIN; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    assign o_b_we      = i_s1.valid && i_s1.bwr;
    assign o_b_waddr   = i_addr;
    assign o_b_wdata   = mid;
    assign o_push      = i_s1.valid && i_s1.produced;
    assign o_res.last  = i_s1.last;
    assign o_res.value = i_s1.calc ? clamped : '0;

endmodule

`default_nettype wire

// File: rtl/core/lsh_out_fifo.sv
`default_nettype none

module lsh_out_fifo
    import lsh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_res                  i_res,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_res                       o_res,
    output logic      [FIFO_CNT_W-1:0] o_count
);

    t_res                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  pop;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    assign pop = (r_cnt != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + FIFO_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// File: rtl/core/laplacian_sharpen_3x3_top.sv
`default_nettype none

// 3x3 Laplacian sharpen over a raster stream of 8-bit channel words, channels
// interleaved. Each interior word becomes 5*centre minus its four same-channel
// neighbours, clamped to 0..255; the first and last rows and pixel columns come
// out as zero. The block takes one word per clock while o_stall is low: an
// accepted word reads the two line RAMs at the edge that accepts it, its result
// is formed from the read data in the next cycle and enters a three-entry output
// queue at the end of that cycle, from which it can leave as long as the output
// side keeps up. Results trail the input by one line plus one pixel, that is
// (width + 1) * channels words; after the last word of a frame the host sends
// that many further words (pad or not) to drain the frame, and the last of them
// carries frame_end. Pad words sent before the frame is complete are dropped. A
// write to any of the three registers restarts the frame. The line RAMs need no
// clearing after reset.
module laplacian_sharpen_3x3_top
    import lsh_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [DATA_W-1:0]    i_sample,
    input  wire logic                 i_pad,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic      [DATA_W-1:0]    o_out_sample,
    output logic                      o_frame_end
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    logic                  accept;
    logic                  a_en;
    logic [AW-1:0]         a_addr;
    logic [DATA_W-1:0]     a_wdata;
    logic [DATA_W-1:0]     a_rdata;
    logic                  b_re;
    logic [AW-1:0]         b_raddr;
    logic [DATA_W-1:0]     b_rdata;
    logic                  b_we;
    logic [AW-1:0]         b_waddr;
    logic [DATA_W-1:0]     b_wdata;
    t_s1                   s1;
    logic [AW-1:0]         s1_addr;
    logic [DATA_W-1:0]     s1_down;
    logic [CH_W-1:0]       chan;
    logic                  push;
    t_res                  res_in;
    t_res                  res_out;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic [FIFO_CNT_W:0]   occupancy;

    // Items in the compute stage always find a free queue entry.
    assign occupancy = {{FIFO_CNT_W{1'b0}}, s1.valid} + {1'b0, fifo_cnt};
    assign o_stall   = (occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept    = i_valid && !o_stall;

    lsh_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_pad       (i_pad),
        .o_a_en      (a_en),
        .o_a_addr    (a_addr),
        .o_a_wdata   (a_wdata),
        .o_b_re      (b_re),
        .o_b_raddr   (b_raddr),
        .o_s1        (s1),
        .o_s1_addr   (s1_addr),
        .o_s1_down   (s1_down),
        .o_chan      (chan)
    );

    // Previous row, read and overwritten at the same position.
    lsh_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_re    (a_en),
        .i_raddr (a_addr),
        .o_rdata (a_rdata),
        .i_we    (a_en),
        .i_waddr (a_addr),
        .i_wdata (a_wdata)
    );

    // Row before that, written one pixel behind the input position.
    lsh_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata)
    );

    lsh_calc #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_addr    (s1_addr),
        .i_down    (s1_down),
        .i_chan    (chan),
        .i_prev    (a_rdata),
        .i_up      (b_rdata),
        .o_b_we    (b_we),
        .o_b_waddr (b_waddr),
        .o_b_wdata (b_wdata),
        .o_push    (push),
        .o_res     (res_in)
    );

    lsh_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res_out),
        .o_count (fifo_cnt)
    );

    assign o_out_sample = res_out.value;
    assign o_frame_end  = res_out.last;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lsh_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int WIN_DEPTH     = 2 * DEF_MAX_CHANNELS + 1;
    localparam int HEIGHT_MAX    = 4095;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 1700;
    localparam int MAX_REPORTS   = 10;
    // Index 3 decodes to no register; a write there must leave the frame alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [DATA_W-1:0]    i_sample    = '0;
    logic                 i_pad       = 1'b0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [DATA_W-1:0]    o_out_sample;
    logic                 o_frame_end;

    laplacian_sharpen_3x3_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_pad        (i_pad),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_sample (o_out_sample),
        .o_frame_end  (o_frame_end)
    );

    // Shadow copy of the filter state.
    bit   [DATA_W-1:0] prev_row  [STORE_DEPTH];
    bit   [DATA_W-1:0] older_row [STORE_DEPTH];
    bit   [DATA_W-1:0] row_window[WIN_DEPTH];
    int unsigned       col_pos   = 0;
    int unsigned       row_pos   = 0;
    logic [CFG_W-1:0]  width_reg  = CFG_W'(RST_FRAME_WIDTH);
    logic [CFG_W-1:0]  height_reg = CFG_W'(RST_FRAME_HEIGHT);
    logic [CH_W-1:0]   chans_reg  = CH_W'(RST_CHANNELS);

    t_res        sharpened_queue[$];
    int unsigned words_taken    = 0;
    int unsigned pixels_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 29;
    int unsigned recv_stall_pct = 65;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic frame_dims(output int unsigned w, output int unsigned h,
                              output int unsigned c);
        w = clamp_dim(32'(width_reg), MIN_DIM, DEF_MAX_WIDTH);
        h = clamp_dim(32'(height_reg), MIN_DIM, HEIGHT_MAX);
        c = clamp_dim(32'(chans_reg), 1, DEF_MAX_CHANNELS);
    endtask

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        row_window = '{default: '0};
    endtask

    // Advances the shadow state by one accepted word and queues the pixel it yields.
    task automatic sharpen_step(input logic [DATA_W-1:0] sample, input logic pad);
        int unsigned w, h, c, len, x, r, li;
        int          v;
        bit [DATA_W-1:0] above;
        bit          produced, last;
        t_res        res;
        frame_dims(w, h, c);
        len = w * c;
        x = col_pos;
        r = row_pos;
        res.value = '0;
        produced = 1'b0;
        last = 1'b0;
        if (r < h) begin
            // Pad words before the frame is complete are dropped outright.
            if (pad) return;
            above = prev_row[x];
            prev_row[x] = sample;
            for (int i = WIN_DEPTH - 1; i > 0; i--) row_window[i] = row_window[i - 1];
            row_window[0] = above;
            if (x >= c) begin
                li = x - c;
                v = 5 * int'(row_window[c]) - int'(older_row[li]) - int'(prev_row[li])
                    - int'(row_window[2 * c]) - int'(row_window[0]);
                older_row[li] = row_window[c];
                if (x >= 2 * c && r >= 2) begin
                    if (v < 0) v = 0;
                    else if (v > 255) v = 255;
                    res.value = DATA_W'(v);
                end
            end
            produced = (r >= 2) || (r == 1 && x >= c);
        end else begin
            // Drain tail: every word yields a border zero, the last one ends the frame.
            produced = 1'b1;
            last = (r > h) && (x + 1 >= c);
        end
        if (produced) begin
            res.last = last;
            sharpened_queue.push_back(res);
        end
        if (last) begin
            restart_frame();
        end else begin
            x++;
            if (x >= len) begin
                x = 0;
                r++;
            end
            col_pos = x;
            row_pos = r;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] want,
                                   input logic [8:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s at pixel %0d: expected %0h, got %0h",
                     what, pixels_checked, want, got);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sharpened_queue.size() == 0) begin
                report_mismatch("unexpected word", '0, {o_frame_end, o_out_sample});
            end else begin
                want = sharpened_queue.pop_front();
                if (o_out_sample !== want.value)
                    report_mismatch("out_sample", 9'(want.value), 9'(o_out_sample));
                if (o_frame_end !== want.last)
                    report_mismatch("frame_end", 9'(want.last), 9'(o_frame_end));
            end
            pixels_checked++;
        end
    end

    task automatic send_word(input logic [DATA_W-1:0] sample, input logic pad);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= sample;
        i_pad    <= pad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_taken++;
        sharpen_step(sample, pad);
    endtask

    // Leaves the input quiet until every queued pixel is out and the pipeline has settled.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sharpened_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_FRAME_WIDTH:   width_reg = value;
            REG_FRAME_HEIGHT:  height_reg = value;
            REG_CHANNEL_COUNT: chans_reg = value[CH_W-1:0];
            default:           return;
        endcase
        restart_frame();
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned c);
        write_reg(REG_FRAME_WIDTH, CFG_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
        write_reg(REG_CHANNEL_COUNT, CFG_W'(c));
    endtask

    task automatic send_samples(input int unsigned count, input bit extreme,
                                input int unsigned pad_pct);
        logic [DATA_W-1:0] s;
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(99) < pad_pct) send_word(DATA_W'($urandom), 1'b1);
            if (extreme) s = $urandom_range(1) ? 8'hFF : 8'h00;
            else s = DATA_W'($urandom);
            send_word(s, 1'b0);
        end
    endtask

    task automatic send_drain();
        int unsigned w, h, c;
        frame_dims(w, h, c);
        for (int unsigned k = 0; k < (w + 1) * c; k++)
            send_word(DATA_W'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic send_frame(input bit extreme, input int unsigned pad_pct);
        int unsigned w, h, c;
        frame_dims(w, h, c);
        send_samples(w * h * c, extreme, pad_pct);
        send_drain();
    endtask

    // Both clamp limits in one small frame, with pad words dropped mid-frame.
    task automatic test_clamp_and_pads();
        logic [DATA_W-1:0] pattern[12] = '{8'h00, 8'h00, 8'hFF, 8'hFF,
                                           8'h00, 8'hFF, 8'h00, 8'hFF,
                                           8'h00, 8'h00, 8'hFF, 8'hFF};
        set_frame(4, 3, 1);
        for (int k = 0; k < 12; k++) begin
            if (k == 0 || k == 5 || k == 11) send_word(8'hA5, 1'b1);
            send_word(pattern[k], 1'b0);
        end
        send_drain();
    endtask

    task automatic test_register_restart();
        // All-zero registers clamp up to a 3x3 frame with one channel.
        set_frame(0, 0, 0);
        send_samples(4, 1'b0, 0);
        write_reg(REG_UNUSED, '1);
        send_samples(5, 1'b0, 25);
        send_drain();
        // A real write in mid-frame throws the partial frame away.
        send_samples(5, 1'b1, 0);
        write_reg(REG_CHANNEL_COUNT, CFG_W'(5));
        send_frame(1'b0, 10);
    endtask

    task automatic test_random_frames();
        int unsigned start, w, h, c, total;
        start = words_taken;
        while (words_taken - start < RANDOM_WORDS) begin
            if (words_taken - start >= 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (words_taken - start >= RANDOM_WORDS / 3) begin
                send_idle_pct = 65;
                recv_stall_pct = 29;
            end
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 6);
            c = $urandom_range(1, 4);
            case ($urandom_range(9))
                0:       w = $urandom_range(0, 2);
                1:       h = $urandom_range(0, 2);
                2:       c = $urandom_range(1) ? 0 : $urandom_range(5, 7);
                default: ;
            endcase
            set_frame(w, h, c);
            repeat ($urandom_range(1, 2))
                send_frame($urandom_range(3) == 0, $urandom_range(2) * 15);
            // Now and then a frame is cut short; the next register write restarts it.
            if ($urandom_range(6) == 0) begin
                frame_dims(w, h, c);
                total = w * h * c;
                send_samples($urandom_range(1, total - 1), 1'b0, 10);
            end
        end
    endtask

    task automatic test_extreme_sizes();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Width and channels above range clamp to the widest row the stores hold,
        // so the first part of that row must stay silent.
        set_frame(32'hFFF, 0, 7);
        send_samples(40, 1'b0, 0);
        // The tallest frame runs well past the first rows and is never finished.
        set_frame(MIN_DIM, HEIGHT_MAX, 1);
        send_samples(60, 1'b1, 5);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_clamp_and_pads();
        test_register_restart();
        test_random_frames();
        test_extreme_sizes();
        wait_idle();
        if (mismatch_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
